// File: hdl/sbcq_pkg.sv
`timescale 1ns / 1ps
// sbcq_pkg: shared types, codes and decode function for the serial bus command queue.
// No dependencies; every other file imports it.
package sbcq_pkg;

  localparam int TX_DEPTH_DEF = 16;
  localparam int RX_DEPTH_DEF = 16;

  localparam int CMD_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int ENTRY_W = CMD_W + BYTE_W;
  localparam int ACT_W   = 3;
  localparam int FUNC_W  = 2;
  localparam int FLAG_W  = 3;
  localparam int MODE_W  = 2;
  localparam int LVL_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = MODE_W;

  localparam logic [LVL_W-1:0] LVL_MAX = 5'd31;

  localparam logic [FUNC_W-1:0] FUNC_SUBMIT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EVENT  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd2;

  localparam logic [CMD_W-1:0] CMD_I2C_READ = 4'd1;
  localparam logic [CMD_W-1:0] CMD_ACK      = 4'd2;
  localparam logic [CMD_W-1:0] CMD_NACK     = 4'd3;
  localparam logic [CMD_W-1:0] CMD_START    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_STOP     = 4'd6;
  localparam logic [CMD_W-1:0] CMD_RESTART  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_SPI_READ = 4'd8;

  localparam logic [ACT_W-1:0] ACT_START   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_STOP    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RECV    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ACK     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_NACK    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RESTART = 3'd5;
  localparam logic [ACT_W-1:0] ACT_LOAD    = 3'd6;

  localparam logic [MODE_W-1:0] MODE_SPI_MASTER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPI_SLAVE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_I2C_MASTER = 2'd2;
  localparam logic [MODE_W-1:0] MODE_I2C_SLAVE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PORT_MODE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_ENABLE = 1'd1;

  // push/pop strobes for one chain of cells
  typedef struct packed {
    logic push;
    logic pop;
  } chain_ctl_t;

  function automatic logic [ACT_W-1:0] issue_decode(input logic [CMD_W-1:0] cmd);
    logic [ACT_W-1:0] act;
    case (cmd)
      CMD_START:    act = ACT_START;
      CMD_STOP:     act = ACT_STOP;
      CMD_I2C_READ: act = ACT_RECV;
      CMD_ACK:      act = ACT_ACK;
      CMD_NACK:     act = ACT_NACK;
      CMD_RESTART:  act = ACT_RESTART;
      default:      act = ACT_LOAD;
    endcase
    return act;
  endfunction

endpackage

// File: hdl/sbcq_if.sv
`timescale 1ns / 1ps
// sbcq_in_if / sbcq_out_if: valid/ready channels for input and result words.
// Depends on sbcq_pkg for field widths.
interface sbcq_in_if
  import sbcq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CMD_W-1:0]  cmd_code;
  logic [BYTE_W-1:0] tx_byte;
  logic [BYTE_W-1:0] rx_byte;
  logic [FLAG_W-1:0] bus_flags;

  modport source (output valid, func, cmd_code, tx_byte, rx_byte, bus_flags, input ready);
  modport sink   (input valid, func, cmd_code, tx_byte, rx_byte, bus_flags, output ready);
endinterface

interface sbcq_out_if
  import sbcq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              issue_valid;
  logic [ACT_W-1:0]  issue_action;
  logic [BYTE_W-1:0] issue_byte;
  logic [BYTE_W-1:0] pop_byte;
  logic [LVL_W-1:0]  rx_level;
  logic              notify;
  logic              release_clock;
  logic              dropped;

  modport source (output valid, issue_valid, issue_action, issue_byte, pop_byte, rx_level,
                  notify, release_clock, dropped, input ready);
  modport sink   (input valid, issue_valid, issue_action, issue_byte, pop_byte, rx_level,
                  notify, release_clock, dropped, output ready);
endinterface

// File: hdl/sbcq_cell.sv
`timescale 1ns / 1ps
// sbcq_cell: one FIFO entry of a shifting chain; loads from its upper neighbor on pop
// or from the push word when it is the next free slot. Uses sbcq_pkg.
module sbcq_cell
  import sbcq_pkg::*;
#(
  parameter int W = ENTRY_W
) (
  input  logic         clk,
  input  logic         shift_en,
  input  logic [W-1:0] shift_in,
  input  logic         load_en,
  input  logic [W-1:0] load_in,
  output logic [W-1:0] data_out
);

  logic [W-1:0] data_r;
  logic [W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (shift_en) begin
      data_nxt = shift_in;
    end else if (load_en) begin
      data_nxt = load_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

// File: hdl/sbcq_chain.sv
`timescale 1ns / 1ps
// sbcq_chain: FIFO built as a row of sbcq_cell; head sits in cell 0, all cells shift down
// on pop, a push writes the cell at the fill level. Uses sbcq_pkg, sbcq_cell.
module sbcq_chain
  import sbcq_pkg::*;
#(
  parameter int DEPTH = TX_DEPTH_DEF,
  parameter int W     = ENTRY_W,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  chain_ctl_t    ctl,
  input  logic [W-1:0]  push_data,
  output logic [W-1:0]  head_data,
  output logic [CW-1:0] level,
  output logic          full
);

  logic [CW-1:0] level_r;
  logic [CW-1:0] level_nxt;
  logic [W-1:0]  cell_q [DEPTH];

  // push and pop never arrive together on one chain
  always_comb begin
    level_nxt = level_r;
    if (ctl.push) begin
      level_nxt = level_r + CW'(1);
    end else if (ctl.pop) begin
      level_nxt = level_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] upper;
    if (i == DEPTH - 1) begin : g_last
      assign upper = cell_q[i];
    end else begin : g_mid
      assign upper = cell_q[i+1];
    end
    sbcq_cell #(.W(W)) u_cell (
      .clk      (clk),
      .shift_en (ctl.pop),
      .shift_in (upper),
      .load_en  (ctl.push && (level_r == CW'(i))),
      .load_in  (push_data),
      .data_out (cell_q[i])
    );
  end

  assign head_data = cell_q[0];
  assign level     = level_r;
  assign full      = (level_r == CW'(DEPTH));

endmodule

// File: hdl/serial_bus_command_queue_top.sv
`timescale 1ns / 1ps
// serial_bus_command_queue_top: command sequencer for a combined SPI/I2C port with
// transmit and receive FIFOs as cell chains. Uses sbcq_pkg, sbcq_if, sbcq_chain.
//
//  channel | dir | handshake      | word
//  in_if   | in  | valid/ready    | func, cmd_code, tx_byte, rx_byte, bus_flags
//  out_if  | out | valid/ready    | issue/pop/level/notify/release/dropped
//  cfg_*   | in  | cfg_we only    | cfg_index selects port_mode or notify_enable
//
// One word per cycle while the output register is free: each input word is decoded
// and its result registered in the same cycle; the FIFO chains shift or load at that edge.
// A word is taken whenever the output register is empty or being drained.
// Synchronous active-low reset empties both FIFOs, clears the in-flight command
// and the config registers.
module serial_bus_command_queue_top
  import sbcq_pkg::*;
#(
  parameter int TX_DEPTH = TX_DEPTH_DEF,
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sbcq_in_if.sink               in_if,
  sbcq_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TCW = $clog2(TX_DEPTH + 1);
  localparam int RCW = $clog2(RX_DEPTH + 1);

  logic [MODE_W-1:0] port_mode_r;
  logic              notify_en_r;
  logic              active_valid_r, active_valid_nxt;
  logic [CMD_W-1:0]  active_cmd_r, active_cmd_nxt;

  logic              out_valid_r;
  logic              issue_valid_r, issue_valid_nxt;
  logic [ACT_W-1:0]  issue_action_r, issue_action_nxt;
  logic [BYTE_W-1:0] issue_byte_r, issue_byte_nxt;
  logic [BYTE_W-1:0] pop_byte_r, pop_byte_nxt;
  logic [LVL_W-1:0]  rx_level_r, rx_level_nxt;
  logic              notify_r, notify_nxt;
  logic              release_r, release_nxt;
  logic              dropped_r, dropped_nxt;

  logic              accept;
  chain_ctl_t        tx_ctl, rx_ctl;
  logic [ENTRY_W-1:0] tx_head;
  logic [TCW-1:0]    tx_level;
  logic              tx_full;
  logic [BYTE_W-1:0] rx_head;
  logic [RCW-1:0]    rx_count;
  logic              rx_full;
  logic [RCW-1:0]    rx_count_nxt;
  logic              capture;
  logic [CMD_W-1:0]  launch_cmd;
  logic [BYTE_W-1:0] launch_byte;
  logic              launch;
  logic [ACT_W-1:0]  launch_act;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_mode_r <= MODE_SPI_MASTER;
      notify_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PORT_MODE:     port_mode_r <= cfg_data[MODE_W-1:0];
        REG_NOTIFY_ENABLE: notify_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (port_mode_r)
      MODE_SPI_MASTER: capture = active_valid_r && (active_cmd_r == CMD_SPI_READ);
      MODE_SPI_SLAVE:  capture = 1'b1;
      MODE_I2C_MASTER: capture = active_valid_r && (active_cmd_r == CMD_I2C_READ);
      default:         capture = (in_if.bus_flags == '0);
    endcase
  end

  assign launch_act = issue_decode(launch_cmd);

  always_comb begin
    tx_ctl           = '0;
    rx_ctl           = '0;
    launch           = 1'b0;
    launch_cmd       = in_if.cmd_code;
    launch_byte      = in_if.tx_byte;
    active_valid_nxt = active_valid_r;
    active_cmd_nxt   = active_cmd_r;
    pop_byte_nxt     = '0;
    notify_nxt       = 1'b0;
    release_nxt      = 1'b0;
    dropped_nxt      = 1'b0;
    case (in_if.func)
      FUNC_SUBMIT: begin
        if (!active_valid_r) begin
          launch = 1'b1;
        end else if (tx_full) begin
          dropped_nxt = 1'b1;
        end else begin
          tx_ctl.push = 1'b1;
        end
      end
      FUNC_EVENT: begin
        if (capture) begin
          if (rx_full) begin
            dropped_nxt = 1'b1;
          end else begin
            rx_ctl.push = 1'b1;
          end
          notify_nxt = notify_en_r;
        end
        if (port_mode_r == MODE_SPI_MASTER || port_mode_r == MODE_I2C_MASTER) begin
          if (tx_level == '0) begin
            active_valid_nxt = 1'b0;
            active_cmd_nxt   = '0;
          end else begin
            tx_ctl.pop  = 1'b1;
            launch      = 1'b1;
            launch_cmd  = tx_head[ENTRY_W-1:BYTE_W];
            launch_byte = tx_head[BYTE_W-1:0];
          end
        end
        release_nxt = (port_mode_r == MODE_I2C_SLAVE);
      end
      FUNC_POP: begin
        if (rx_count != '0) begin
          pop_byte_nxt = rx_head;
          rx_ctl.pop   = 1'b1;
        end
      end
      default: ;
    endcase
    if (launch) begin
      active_valid_nxt = 1'b1;
      active_cmd_nxt   = launch_cmd;
    end
    issue_valid_nxt  = launch;
    issue_action_nxt = launch ? launch_act : '0;
    issue_byte_nxt   = (launch && launch_act == ACT_LOAD) ? launch_byte : '0;
    // gate strobes so the FIFOs only move on an accepted word
    tx_ctl.push = tx_ctl.push && accept;
    tx_ctl.pop  = tx_ctl.pop && accept;
    rx_ctl.push = rx_ctl.push && accept;
    rx_ctl.pop  = rx_ctl.pop && accept;
  end

  always_comb begin
    rx_count_nxt = rx_count;
    if (rx_ctl.push) begin
      rx_count_nxt = rx_count + RCW'(1);
    end else if (rx_ctl.pop) begin
      rx_count_nxt = rx_count - RCW'(1);
    end
    rx_level_nxt = (32'(rx_count_nxt) > 32'(LVL_MAX)) ? LVL_MAX : LVL_W'(rx_count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_valid_r <= 1'b0;
      active_cmd_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        active_valid_r <= active_valid_nxt;
        active_cmd_r   <= active_cmd_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      issue_valid_r  <= issue_valid_nxt;
      issue_action_r <= issue_action_nxt;
      issue_byte_r   <= issue_byte_nxt;
      pop_byte_r     <= pop_byte_nxt;
      rx_level_r     <= rx_level_nxt;
      notify_r       <= notify_nxt;
      release_r      <= release_nxt;
      dropped_r      <= dropped_nxt;
    end
  end

  sbcq_chain #(.DEPTH(TX_DEPTH), .W(ENTRY_W)) u_tx_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (tx_ctl),
    .push_data ({in_if.cmd_code, in_if.tx_byte}),
    .head_data (tx_head),
    .level     (tx_level),
    .full      (tx_full)
  );

  sbcq_chain #(.DEPTH(RX_DEPTH), .W(BYTE_W)) u_rx_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rx_ctl),
    .push_data (in_if.rx_byte),
    .head_data (rx_head),
    .level     (rx_count),
    .full      (rx_full)
  );

  assign out_if.valid         = out_valid_r;
  assign out_if.issue_valid   = issue_valid_r;
  assign out_if.issue_action  = issue_action_r;
  assign out_if.issue_byte    = issue_byte_r;
  assign out_if.pop_byte      = pop_byte_r;
  assign out_if.rx_level      = rx_level_r;
  assign out_if.notify        = notify_r;
  assign out_if.release_clock = release_r;
  assign out_if.dropped       = dropped_r;

endmodule

// File: tb/sbcq_checker.sv
`timescale 1ns / 1ps
// sbcq_checker: watches the input, result and config ports of the command queue,
// predicts each result word and compares it. Depends on sbcq_pkg and sbcq_if.
module sbcq_checker
  import sbcq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  sbcq_in_if                    in_ch,
  sbcq_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    outstanding
);

  typedef struct packed {
    logic              issue_valid;
    logic [ACT_W-1:0]  issue_action;
    logic [BYTE_W-1:0] issue_byte;
    logic [BYTE_W-1:0] pop_byte;
    logic [LVL_W-1:0]  rx_level;
    logic              notify;
    logic              release_clock;
    logic              dropped;
  } bus_result_t;

  // shadow of the block's config and queue state
  logic [MODE_W-1:0] mode_q;
  logic              notify_q;
  logic              busy;
  logic [CMD_W-1:0]  cur_cmd;
  logic [ENTRY_W-1:0] tx_mem [TX_DEPTH_DEF];
  logic [BYTE_W-1:0]  rx_mem [RX_DEPTH_DEF];
  int unsigned tx_rd, tx_wr, tx_cnt;
  int unsigned rx_rd, rx_wr, rx_cnt;

  bus_result_t results_due[$];
  int fail_cnt = 0;
  int result_idx = 0;

  function automatic void launch_cmd(inout bus_result_t r, input logic [CMD_W-1:0] cmd,
                                     input logic [BYTE_W-1:0] b);
    busy = 1'b1;
    cur_cmd = cmd;
    r.issue_valid = 1'b1;
    case (cmd)
      CMD_START:    r.issue_action = ACT_START;
      CMD_STOP:     r.issue_action = ACT_STOP;
      CMD_I2C_READ: r.issue_action = ACT_RECV;
      CMD_ACK:      r.issue_action = ACT_ACK;
      CMD_NACK:     r.issue_action = ACT_NACK;
      CMD_RESTART:  r.issue_action = ACT_RESTART;
      default:      r.issue_action = ACT_LOAD;
    endcase
    r.issue_byte = (r.issue_action == ACT_LOAD) ? b : '0;
  endfunction

  function automatic bus_result_t next_bus_result(input logic [FUNC_W-1:0] f,
                                                  input logic [CMD_W-1:0] cmd,
                                                  input logic [BYTE_W-1:0] txb,
                                                  input logic [BYTE_W-1:0] rxb,
                                                  input logic [FLAG_W-1:0] flags);
    bus_result_t r;
    logic take;
    logic [ENTRY_W-1:0] e;
    r = '0;
    case (f)
      FUNC_SUBMIT: begin
        if (!busy) begin
          launch_cmd(r, cmd, txb);
        end else if (tx_cnt >= TX_DEPTH_DEF) begin
          r.dropped = 1'b1;
        end else begin
          tx_mem[tx_wr] = {cmd, txb};
          tx_wr = (tx_wr + 1) % TX_DEPTH_DEF;
          tx_cnt++;
        end
      end
      FUNC_EVENT: begin
        case (mode_q)
          MODE_SPI_MASTER: take = busy && cur_cmd == CMD_SPI_READ;
          MODE_SPI_SLAVE:  take = 1'b1;
          MODE_I2C_MASTER: take = busy && cur_cmd == CMD_I2C_READ;
          default:         take = (flags == '0);
        endcase
        if (take) begin
          if (rx_cnt >= RX_DEPTH_DEF) begin
            r.dropped = 1'b1;
          end else begin
            rx_mem[rx_wr] = rxb;
            rx_wr = (rx_wr + 1) % RX_DEPTH_DEF;
            rx_cnt++;
          end
          // notify fires even when the byte is lost
          r.notify = notify_q;
        end
        if (mode_q == MODE_SPI_MASTER || mode_q == MODE_I2C_MASTER) begin
          if (tx_cnt == 0) begin
            busy = 1'b0;
            cur_cmd = '0;
          end else begin
            e = tx_mem[tx_rd];
            tx_rd = (tx_rd + 1) % TX_DEPTH_DEF;
            tx_cnt--;
            launch_cmd(r, e[ENTRY_W-1:BYTE_W], e[BYTE_W-1:0]);
          end
        end
        if (mode_q == MODE_I2C_SLAVE) r.release_clock = 1'b1;
      end
      FUNC_POP: begin
        if (rx_cnt > 0) begin
          r.pop_byte = rx_mem[rx_rd];
          rx_rd = (rx_rd + 1) % RX_DEPTH_DEF;
          rx_cnt--;
        end
      end
      default: ;
    endcase
    r.rx_level = (rx_cnt > LVL_MAX) ? LVL_MAX : LVL_W'(rx_cnt);
    return r;
  endfunction

  function automatic string show(input bus_result_t r);
    return $sformatf("iv=%0d act=%0d ib=%02h pb=%02h lvl=%0d ntf=%0d rel=%0d drop=%0d",
                     r.issue_valid, r.issue_action, r.issue_byte, r.pop_byte, r.rx_level,
                     r.notify, r.release_clock, r.dropped);
  endfunction

  task automatic note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("[%0t] word %0d: %s", $realtime, result_idx, msg);
  endtask

  always @(posedge clk) begin
    bus_result_t got;
    bus_result_t want;
    if (!rst_n) begin
      mode_q = MODE_SPI_MASTER;
      notify_q = 1'b0;
      busy = 1'b0;
      cur_cmd = '0;
      tx_rd = 0;
      tx_wr = 0;
      tx_cnt = 0;
      rx_rd = 0;
      rx_wr = 0;
      rx_cnt = 0;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_PORT_MODE) mode_q = cfg_data[MODE_W-1:0];
        else if (cfg_index == REG_NOTIFY_ENABLE) notify_q = cfg_data[0];
      end
      if (out_ch.valid && out_ch.ready) begin
        got.issue_valid   = out_ch.issue_valid;
        got.issue_action  = out_ch.issue_action;
        got.issue_byte    = out_ch.issue_byte;
        got.pop_byte      = out_ch.pop_byte;
        got.rx_level      = out_ch.rx_level;
        got.notify        = out_ch.notify;
        got.release_clock = out_ch.release_clock;
        got.dropped       = out_ch.dropped;
        if (results_due.size() == 0) begin
          note_failure($sformatf("unexpected result %s", show(got)));
        end else begin
          want = results_due.pop_front();
          if (got !== want)
            note_failure($sformatf("mismatch\n  exp %s\n  got %s", show(want), show(got)));
        end
        result_idx++;
      end
      if (in_ch.valid && in_ch.ready)
        results_due.push_back(next_bus_result(in_ch.func, in_ch.cmd_code, in_ch.tx_byte,
                                              in_ch.rx_byte, in_ch.bus_flags));
    end
    errors <= fail_cnt;
    outstanding <= results_due.size();
  end

endmodule

// File: tb/serial_bus_command_queue_top_tb.sv
`timescale 1ns / 1ps
// serial_bus_command_queue_top_tb: clock, reset, config phases and paced stimulus for
// the command queue, with a stalling result receiver. Uses sbcq_pkg, sbcq_if, sbcq_checker.
module serial_bus_command_queue_top_tb;
  import sbcq_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED   = 2'd3;
  localparam logic [CMD_W-1:0]  CMD_I2C_WRITE = 4'd0;
  localparam logic [CMD_W-1:0]  CMD_ADDRESS   = 4'd4;
  localparam logic [CMD_W-1:0]  CMD_SPI_WRITE = 4'd9;
  localparam logic [CMD_W-1:0]  CMD_MAX       = 4'hF;

  localparam int RANDOM_WORDS   = 1650;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int STALL_LIMIT    = 4000;

  typedef enum int {MIX_BALANCED, MIX_SUBMIT, MIX_EVENT, MIX_POP, MIX_NOISE} mix_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int   errors;
  int   outstanding;
  logic squeeze_go;
  logic squeeze_done;
  int   sent = 0;
  int   burst_left = 0;

  sbcq_in_if  in_ch ();
  sbcq_out_if out_ch ();

  serial_bus_command_queue_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sbcq_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  function automatic logic [BYTE_W-1:0] rand_byte();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return BYTE_W'($urandom());
  endfunction

  // Offer one word and hold it until taken; bursts are separated by random gaps,
  // except while the receiver is being squeezed.
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [CMD_W-1:0] cmd,
                           input logic [BYTE_W-1:0] txb, input logic [BYTE_W-1:0] rxb,
                           input logic [FLAG_W-1:0] flags);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0 && !(squeeze_go && !squeeze_done)) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.cmd_code  <= cmd;
    in_ch.tx_byte   <= txb;
    in_ch.rx_byte   <= rxb;
    in_ch.bus_flags <= flags;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_all();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_port(input logic [MODE_W-1:0] mode, input logic notify_on);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PORT_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= REG_NOTIFY_ENABLE;
    cfg_data  <= CFG_DATA_W'(notify_on);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_word(input mix_t mix);
    logic [FUNC_W-1:0] f;
    logic [CMD_W-1:0]  cmd;
    logic [FLAG_W-1:0] flags;
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_SUBMIT: f = (roll < 80) ? FUNC_SUBMIT : (roll < 95) ? FUNC_EVENT : FUNC_POP;
      MIX_EVENT:  f = (roll < 10) ? FUNC_SUBMIT : (roll < 95) ? FUNC_EVENT : FUNC_POP;
      MIX_POP:    f = (roll < 10) ? FUNC_SUBMIT : (roll < 30) ? FUNC_EVENT : FUNC_POP;
      MIX_NOISE:  f = (roll < 8) ? FUNC_UNUSED : FUNC_W'($urandom_range(0, 2));
      default:    f = (roll < 40) ? FUNC_SUBMIT : (roll < 80) ? FUNC_EVENT : FUNC_POP;
    endcase
    roll = $urandom_range(0, 99);
    if (mix == MIX_NOISE && roll < 30) cmd = CMD_W'($urandom_range(CMD_SPI_WRITE + 1, CMD_MAX));
    else if (roll < 35) cmd = roll[0] ? CMD_I2C_READ : CMD_SPI_READ;
    else cmd = CMD_W'($urandom_range(0, CMD_SPI_WRITE));
    flags = '0;
    if ($urandom_range(0, 1) == 1) flags = FLAG_W'($urandom_range(1, 7));
    send_word(f, cmd, rand_byte(), rand_byte(), flags);
    sent++;
  endtask

  initial begin
    int phase;
    int plen;
    int clen;
    mix_t mix;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_PORT_MODE;
    cfg_data        <= '0;
    squeeze_go      <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FUNC_SUBMIT;
    in_ch.cmd_code  <= '0;
    in_ch.tx_byte   <= '0;
    in_ch.rx_byte   <= '0;
    in_ch.bus_flags <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // SPI master out of reset: unused func, launch, queue, capture rule, pops
    send_word(FUNC_UNUSED, CMD_MAX, 8'hFF, 8'hFF, '1);
    send_word(FUNC_SUBMIT, CMD_SPI_WRITE, 8'hFF, 8'h00, '0);
    send_word(FUNC_SUBMIT, CMD_SPI_READ, 8'h00, 8'hFF, '1);
    send_word(FUNC_POP, CMD_I2C_WRITE, 8'h00, 8'h00, '0);
    send_word(FUNC_EVENT, CMD_I2C_WRITE, 8'h00, 8'h5A, '0);
    send_word(FUNC_EVENT, CMD_I2C_WRITE, 8'h00, 8'hFF, '0);
    send_word(FUNC_POP, CMD_I2C_WRITE, 8'h00, 8'h00, '0);
    send_word(FUNC_EVENT, CMD_ADDRESS, 8'hFF, 8'h00, '1);

    // I2C master: start goes out, every other code (unused ones too) is queued
    drain_all();
    set_port(MODE_I2C_MASTER, 1'b1);
    send_word(FUNC_SUBMIT, CMD_START, 8'hA5, 8'h00, '0);
    for (int c = 0; c <= CMD_MAX; c++)
      if (CMD_W'(c) != CMD_START) send_word(FUNC_SUBMIT, CMD_W'(c), rand_byte(), 8'h00, '0);

    phase = 0;
    while (sent < RANDOM_WORDS) begin
      drain_all();
      if (phase < 8) set_port(MODE_W'(phase), phase[2]);
      else set_port(MODE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      if (phase == 9) squeeze_go <= 1'b1;
      plen = $urandom_range(60, 160);
      while (plen > 0 && sent < RANDOM_WORDS) begin
        mix = mix_t'($urandom_range(0, 4));
        clen = $urandom_range(8, 40);
        while (clen > 0 && plen > 0 && sent < RANDOM_WORDS) begin
          random_word(mix);
          clen--;
          plen--;
        end
      end
      phase++;
    end

    drain_all();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result receiver: phases of always-ready, random, sparse and periodic ready,
  // plus one long hold-off while the sender keeps pushing
  initial begin
    int mode;
    int left;
    int tick;
    int period;
    mode = 0;
    left = 0;
    tick = 0;
    period = 2;
    out_ch.ready <= 1'b0;
    squeeze_done <= 1'b0;
    @(posedge clk);
    forever begin
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 150);
        period = $urandom_range(2, 6);
      end
      left--;
      tick++;
      if (squeeze_go && !squeeze_done) begin
        out_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_done <= 1'b1;
      end
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (tick % period == 0);
      endcase
      @(posedge clk);
    end
  end

  // watchdog on cycles with no handshake on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
